// File: hw/rtl/brd_pkg.sv
// ----------------------------------------------------------------------------
// brd_pkg
// Shared widths, constants, controller states and the xorshift step for the
// bounded random draw block.
// ----------------------------------------------------------------------------
package brd_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned StateW   = 2 * WordW;
  localparam int unsigned CountW   = $clog2(WordW);

  localparam int unsigned ShiftA   = 13;
  localparam int unsigned ShiftB   = 7;
  localparam int unsigned ShiftC   = 17;

  localparam logic [StateW-1:0] SeedReset = StateW'(777);

  typedef logic [WordW-1:0]  word_t;
  typedef logic [StateW-1:0] dword_t;
  typedef logic [CountW-1:0] count_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_DIV,
    ST_OUT
  } brd_state_e;

  function automatic dword_t brd_xorshift(dword_t s);
    dword_t t;
    t = s ^ (s << ShiftA);
    t = t ^ (t >> ShiftB);
    t = t ^ (t << ShiftC);
    return t;
  endfunction

endpackage

// File: hw/rtl/brd_range_if.sv
// ----------------------------------------------------------------------------
// brd_range_if
// Request channel: valid/ready handshake carrying the exclusive upper bound.
// ----------------------------------------------------------------------------
interface brd_range_if;
  logic                valid;
  logic                ready;
  brd_pkg::word_t      range;

  modport source (output valid, output range, input ready);
  modport sink   (input valid, input range, output ready);
endinterface

// File: hw/rtl/brd_value_if.sv
// ----------------------------------------------------------------------------
// brd_value_if
// Result channel: valid/ready handshake carrying the drawn value.
// ----------------------------------------------------------------------------
interface brd_value_if;
  logic                valid;
  logic                ready;
  brd_pkg::word_t      value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// File: hw/rtl/brd_thresh.sv
// ----------------------------------------------------------------------------
// brd_thresh
// Bit-serial restoring remainder: (2^32 - divisor) mod divisor, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module brd_thresh (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  brd_pkg::word_t divisor_i,
  output logic           done_o,
  output brd_pkg::word_t rem_o
);
  import brd_pkg::*;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  count_t        cnt_q, cnt_d;
  word_t         num_q, num_d;
  word_t         rem_q, rem_d;
  word_t         div_q, div_d;
  logic [WordW:0] trial;
  logic [WordW:0] diff;

  always_comb begin
    trial  = {rem_q, num_q[WordW-1]};
    diff   = trial - {1'b0, div_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = word_t'(0) - divisor_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      num_d = num_q << 1;
      if (!diff[WordW]) begin
        rem_d = diff[WordW-1:0];
      end else begin
        rem_d = trial[WordW-1:0];
      end
      cnt_d = cnt_q + count_t'(1);
      if (cnt_q == count_t'(WordW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// File: hw/rtl/bounded_random_draw.sv
// ----------------------------------------------------------------------------
// bounded_random_draw
// Unbiased integer in [0, range) from a 64-bit xorshift source, by
// multiply-and-reject with a lazily formed threshold.
// ----------------------------------------------------------------------------
// Each request word is accepted in ST_IDLE, run through the bit-serial
// multiplier in ST_MUL, checked in ST_CHECK and registered in ST_OUT.
// When the low product half falls below the range and no threshold is held,
// the threshold is formed by the bit-serial remainder unit in ST_DIV, and every
// rejected source word goes through the multiplier again. A new request is
// taken while the previous result still waits on the output register. Seed
// writes of zero are ignored; a pending lower half survives a seed write.
module bounded_random_draw (
  input  logic           clk_i,
  input  logic           rst_ni,
  brd_range_if.sink      req_i,
  brd_value_if.source    rsp_o,
  input  logic           seed_we_i,
  input  brd_pkg::word_t seed_wdata_i
);
  import brd_pkg::*;

  brd_state_e state_q, state_d;

  dword_t src_q, src_d;
  word_t  pend_q, pend_d;
  logic   pend_valid_q, pend_valid_d;
  word_t  range_q, range_d;
  word_t  mplr_q, mplr_d;
  dword_t acc_q, acc_d;
  count_t cnt_q, cnt_d;
  word_t  thr_q, thr_d;
  logic   thr_valid_q, thr_valid_d;
  logic   out_valid_q, out_valid_d;
  word_t  out_value_q, out_value_d;

  logic   accept;
  logic   draw_en;
  logic   mul_last;
  logic   low_lt_range;
  logic   low_lt_thr;
  logic   out_free;
  logic   div_start;
  logic   div_done;
  word_t  div_rem;
  dword_t adv;
  word_t  draw_word;
  logic [WordW:0] sum;

  assign accept       = req_i.valid && (state_q == ST_IDLE);
  assign mul_last     = (cnt_q == count_t'(WordW - 1));
  assign low_lt_range = acc_q[WordW-1:0] < range_q;
  assign low_lt_thr   = acc_q[WordW-1:0] < thr_q;
  assign out_free     = !out_valid_q || rsp_o.ready;
  assign adv          = brd_xorshift(src_q);
  assign draw_word    = pend_valid_q ? pend_q : adv[StateW-1:WordW];

  brd_thresh u_thresh (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (range_q),
    .done_o    (div_done),
    .rem_o     (div_rem)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_MUL;
      end
      ST_MUL: begin
        if (mul_last) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (!thr_valid_q) begin
          state_d = low_lt_range ? ST_DIV : ST_OUT;
        end else begin
          state_d = low_lt_thr ? ST_MUL : ST_OUT;
        end
      end
      ST_DIV: begin
        if (div_done) state_d = ST_CHECK;
      end
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    draw_en   = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE:  draw_en = accept;
      ST_CHECK: begin
        if (!thr_valid_q) begin
          div_start = low_lt_range;
        end else begin
          draw_en = low_lt_thr;
        end
      end
      default: begin
        draw_en   = 1'b0;
        div_start = 1'b0;
      end
    endcase
  end

  // datapath
  always_comb begin
    src_d        = src_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    range_d      = range_q;
    mplr_d       = mplr_q;
    acc_d        = acc_q;
    cnt_d        = cnt_q;
    thr_d        = thr_q;
    thr_valid_d  = thr_valid_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_value_d  = out_value_q;
    sum          = {1'b0, acc_q[StateW-1:WordW]} + (mplr_q[0] ? {1'b0, range_q} : '0);

    if (seed_we_i && (seed_wdata_i != '0)) begin
      src_d = {word_t'(0), seed_wdata_i};
    end

    if (accept) begin
      range_d     = req_i.range;
      thr_valid_d = 1'b0;
    end

    if (draw_en) begin
      if (pend_valid_q) begin
        pend_valid_d = 1'b0;
      end else begin
        src_d        = adv;
        pend_d       = adv[WordW-1:0];
        pend_valid_d = 1'b1;
      end
      mplr_d = draw_word;
      acc_d  = '0;
      cnt_d  = '0;
    end

    if (state_q == ST_MUL) begin
      acc_d  = {sum, acc_q[WordW-1:1]};
      mplr_d = mplr_q >> 1;
      cnt_d  = cnt_q + count_t'(1);
    end

    if ((state_q == ST_DIV) && div_done) begin
      thr_d       = div_rem;
      thr_valid_d = 1'b1;
    end

    if ((state_q == ST_OUT) && out_free) begin
      out_valid_d = 1'b1;
      out_value_d = acc_q[StateW-1:WordW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      src_q        <= SeedReset;
      pend_q       <= '0;
      pend_valid_q <= 1'b0;
      cnt_q        <= '0;
      thr_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      src_q        <= src_d;
      pend_q       <= pend_d;
      pend_valid_q <= pend_valid_d;
      cnt_q        <= cnt_d;
      thr_valid_q  <= thr_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    range_q     <= range_d;
    mplr_q      <= mplr_d;
    acc_q       <= acc_d;
    thr_q       <= thr_d;
    out_value_q <= out_value_d;
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.value = out_value_q;

endmodule
